### rtl/assert_macros.svh
// Assertion macros shared by the frame receiver RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies a property in the next.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### rtl/crcfr_pkg.sv
// Shared types, constants and the CRC-32 byte step for the frame receiver.
// Depends on nothing; used by crcfr_parser and crc32_frame_receiver.
package crcfr_pkg;

	// Defaults and fixed constants
	localparam int unsigned LengthBitsDefault = 16;
	localparam logic [31:0] CrcInit           = 32'hFFFF_FFFF;
	localparam logic [31:0] CrcPoly           = 32'hEDB8_8320;
	localparam int unsigned CrcBytes          = 4;

	// Configuration register indexes
	localparam logic [1:0] CFG_MIN_LENGTH    = 2'd0;
	localparam logic [1:0] CFG_MAX_LENGTH    = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

	localparam logic [15:0] MinLengthReset    = 16'd1;
	localparam logic [15:0] MaxLengthReset    = 16'd512;
	localparam logic [31:0] TimeoutTicksReset = 32'd100;

	// Item kinds
	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_TICK  = 1'b1;
	localparam logic KIND_BODY    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict codes
	localparam logic [1:0] VERDICT_OK      = 2'd0;
	localparam logic [1:0] VERDICT_BADCRC  = 2'd1;
	localparam logic [1:0] VERDICT_BADLEN  = 2'd2;
	localparam logic [1:0] VERDICT_TIMEOUT = 2'd3;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_data;
	} in_item_t;

	typedef struct packed {
		logic        out_kind;
		logic [7:0]  body_byte;
		logic        is_opcode;
		logic [1:0]  verdict;
		logic [15:0] frame_length;
	} out_item_t;

	typedef struct packed {
		logic [15:0] min_length;
		logic [15:0] max_length;
		logic [31:0] timeout_ticks;
	} cfg_t;

	// Reflected CRC-32 update by one byte, one bit per step
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### rtl/crc32_frame_receiver.sv
// Top level of the length-prefixed frame receiver with CRC-32 check.
// Depends on crcfr_pkg, crcfr_parser and assert_macros.svh.

// Takes one transaction per clock unless in_stall is high: a received byte or
// a time tick. Each transaction is parsed and CRC-updated combinationally;
// its result, if any, goes to the output register, or to the skid register
// while the output stalls. Body bytes are passed on as they arrive, so the
// consumer must hold them until the frame verdict (ok, bad crc, bad length or
// timeout). A skid register behind the output register lets input keep flowing
// while a result waits; in_stall rises only when both are full. Throughput is
// one transaction per cycle while in_stall is low, set by the byte-wide CRC
// step and parser update. Configuration writes take effect on the next cycle
// and are meant for an idle receiver. No clearing pass after reset.
`include "assert_macros.svh"

module crc32_frame_receiver #(
	parameter int unsigned LENGTH_BITS = crcfr_pkg::LengthBitsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  crcfr_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output crcfr_pkg::out_item_t out_data
);
	import crcfr_pkg::*;

	cfg_t      cfg_q;
	logic      fire;
	logic      res_valid;
	out_item_t res;
	logic      out_valid_q;
	out_item_t out_q;
	logic      skid_valid_q;
	out_item_t skid_q;
	logic      out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length    <= MinLengthReset;
			cfg_q.max_length    <= MaxLengthReset;
			cfg_q.timeout_ticks <= TimeoutTicksReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_LENGTH:    cfg_q.min_length    <= cfg_data[15:0];
				CFG_MAX_LENGTH:    cfg_q.max_length    <= cfg_data[15:0];
				CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = skid_valid_q;
	assign fire     = in_valid && !skid_valid_q;

	crcfr_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (in_data),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res      (res)
	);

	assign out_free = !out_valid_q || !out_stall;

	// Output register with skid stage; refill from skid first to keep order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= skid_valid_q && res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
			if (skid_valid_q) begin
				skid_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_ALWAYS(a_skid_implies_out, clk, arst_n, !skid_valid_q || out_valid_q, "skid holds a transaction while output register is empty")
	`ASSERT_NEXT(a_skid_kept_while_stalled, clk, arst_n, skid_valid_q && out_stall, skid_valid_q && $stable(skid_q), "skid transaction lost while output stalled")

endmodule

### rtl/crcfr_parser.sv
// Frame parser: length, body and CRC phases, CRC-32 check and idle timeout.
// Depends on crcfr_pkg and assert_macros.svh; instantiated by crc32_frame_receiver.
`include "assert_macros.svh"

module crcfr_parser #(
	parameter int unsigned LENGTH_BITS = crcfr_pkg::LengthBitsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  crcfr_pkg::in_item_t  item,
	input  crcfr_pkg::cfg_t      cfg,
	output logic                 res_valid,
	output crcfr_pkg::out_item_t res
);
	import crcfr_pkg::*;

	localparam logic [16:0] LenLimit = (17'd1 << LENGTH_BITS) - 17'd1;
	localparam int unsigned CntW     = LENGTH_BITS + 1;

	typedef enum logic [1:0] {
		PH_LEN_HI = 2'd0,
		PH_LEN_LO = 2'd1,
		PH_BODY   = 2'd2,
		PH_CRC    = 2'd3
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [15:0]            ann_len_q, ann_len_d;
	logic [LENGTH_BITS-1:0] count_q, count_d;
	logic [31:0]            crc_q, crc_d;
	logic [31:0]            rcv_crc_q, rcv_crc_d;
	logic [31:0]            idle_q, idle_d;

	logic [31:0]    crc_upd;
	logic [CntW-1:0] count_inc;
	logic [31:0]    idle_inc;
	logic [15:0]    len_lo;
	logic [31:0]    rcv_shift;
	logic           clear;

	assign crc_upd   = crc32_byte(crc_q, item.rx_data);
	assign count_inc = {1'b0, count_q} + CntW'(1);
	assign idle_inc  = (idle_q == 32'hFFFF_FFFF) ? idle_q : idle_q + 32'd1;
	assign len_lo    = {ann_len_q[15:8], item.rx_data};
	assign rcv_shift = {rcv_crc_q[23:0], item.rx_data};

	// Next state and result for one transaction
	always_comb begin
		phase_d   = phase_q;
		ann_len_d = ann_len_q;
		count_d   = count_q;
		crc_d     = crc_q;
		rcv_crc_d = rcv_crc_q;
		idle_d    = idle_q;
		clear     = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		if (fire) begin
			if (item.cmd == CMD_TICK) begin
				// Count idle time only while a frame is under way
				if (phase_q != PH_LEN_HI) begin
					idle_d = idle_inc;
					if (idle_inc > cfg.timeout_ticks) begin
						res_valid        = 1'b1;
						res.out_kind     = KIND_VERDICT;
						res.verdict      = VERDICT_TIMEOUT;
						res.frame_length = ann_len_q;
						clear            = 1'b1;
					end
				end
			end else begin
				idle_d = '0;
				unique case (phase_q)
					PH_LEN_HI: begin
						crc_d     = crc_upd;
						ann_len_d = {item.rx_data, 8'd0};
						phase_d   = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						crc_d     = crc_upd;
						ann_len_d = len_lo;
						count_d   = '0;
						if (len_lo < cfg.min_length || len_lo > cfg.max_length ||
						    {1'b0, len_lo} > LenLimit) begin
							res_valid        = 1'b1;
							res.out_kind     = KIND_VERDICT;
							res.verdict      = VERDICT_BADLEN;
							res.frame_length = len_lo;
							clear            = 1'b1;
						end else begin
							phase_d = (len_lo == 16'd0) ? PH_CRC : PH_BODY;
						end
					end
					PH_BODY: begin
						// Pass the byte on; downstream holds it until the verdict
						crc_d         = crc_upd;
						res_valid     = 1'b1;
						res.out_kind  = KIND_BODY;
						res.body_byte = item.rx_data;
						res.is_opcode = (count_q == '0);
						if (17'(count_inc) >= {1'b0, ann_len_q}) begin
							count_d = '0;
							phase_d = PH_CRC;
						end else begin
							count_d = count_inc[LENGTH_BITS-1:0];
						end
					end
					PH_CRC: begin
						rcv_crc_d = rcv_shift;
						count_d   = count_inc[LENGTH_BITS-1:0];
						if (count_inc >= CntW'(CrcBytes)) begin
							res_valid        = 1'b1;
							res.out_kind     = KIND_VERDICT;
							res.verdict      = ((crc_q ^ CrcInit) == rcv_shift) ?
							                   VERDICT_OK : VERDICT_BADCRC;
							res.frame_length = ann_len_q;
							clear            = 1'b1;
						end
					end
					default: begin
						phase_d = PH_LEN_HI;
					end
				endcase
			end
		end
	end

	// Hold parser state; a verdict drops the frame back to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN_HI;
			ann_len_q <= '0;
			count_q   <= '0;
			crc_q     <= CrcInit;
			rcv_crc_q <= '0;
			idle_q    <= '0;
		end else if (clear) begin
			phase_q   <= PH_LEN_HI;
			ann_len_q <= '0;
			count_q   <= '0;
			crc_q     <= CrcInit;
			rcv_crc_q <= '0;
			idle_q    <= '0;
		end else begin
			phase_q   <= phase_d;
			ann_len_q <= ann_len_d;
			count_q   <= count_d;
			crc_q     <= crc_d;
			rcv_crc_q <= rcv_crc_d;
			idle_q    <= idle_d;
		end
	end

	`ASSERT_ALWAYS(a_idle_clear_between_frames, clk, arst_n, (phase_q != PH_LEN_HI) || (idle_q == '0), "idle count nonzero while waiting for a frame")
	`ASSERT_ALWAYS(a_body_count_in_range, clk, arst_n, (phase_q != PH_BODY) || ({1'b0, count_q} < 17'(ann_len_q)), "body count reached announced length")
	`ASSERT_ALWAYS(a_crc_count_in_range, clk, arst_n, (phase_q != PH_CRC) || (32'(count_q) < 32'(CrcBytes)), "CRC byte count out of range")

endmodule

### tb/tb.sv
// Self-checking bench for crc32_frame_receiver: directed frames, then random
// config phases with well-formed, broken and noise byte/tick traffic.
// Depends on crcfr_pkg and the receiver RTL.
module tb;
	import crcfr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned RANDOM_ITEMS = 600;
	localparam int unsigned WHOLE_FRAME = 1 << 30;

	typedef enum logic [1:0] {
		WAIT_LEN_HI,
		WAIT_LEN_LO,
		TAKE_BODY,
		TAKE_CRC
	} rx_phase_t;

	// Tracks receiver state and holds the results it should produce, in order
	class frame_checker;
		logic [15:0] min_len;
		logic [15:0] max_len;
		logic [31:0] tick_limit;
		rx_phase_t   phase;
		logic [15:0] frame_len;
		logic [15:0] byte_count;
		logic [31:0] crc_acc;
		logic [31:0] crc_seen;
		logic [31:0] idle_count;
		out_item_t   pending[$];
		int          errors;

		function new();
			min_len    = MinLengthReset;
			max_len    = MaxLengthReset;
			tick_limit = TimeoutTicksReset;
			errors     = 0;
			clear_frame();
		endfunction

		static function logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
			logic [31:0] r;
			r = c ^ {24'h0, b};
			repeat (8) begin
				if (r[0]) begin
					r = (r >> 1) ^ CrcPoly;
				end else begin
					r = r >> 1;
				end
			end
			return r;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [31:0] val);
			case (idx)
				CFG_MIN_LENGTH:    min_len = val[15:0];
				CFG_MAX_LENGTH:    max_len = val[15:0];
				CFG_TIMEOUT_TICKS: tick_limit = val;
				default: ;
			endcase
		endfunction

		function void clear_frame();
			phase      = WAIT_LEN_HI;
			frame_len  = '0;
			byte_count = '0;
			crc_acc    = CrcInit;
			crc_seen   = '0;
			idle_count = '0;
		endfunction

		function void push_verdict(input logic [1:0] v, input logic [15:0] len);
			out_item_t r;
			r = '0;
			r.out_kind = KIND_VERDICT;
			r.verdict = v;
			r.frame_length = len;
			pending.push_back(r);
			clear_frame();
		endfunction

		// Advance the parser by one accepted transaction
		function void note_item(input in_item_t it);
			out_item_t r;
			logic [7:0] b;
			b = it.rx_data;
			if (it.cmd == CMD_TICK) begin
				if (phase != WAIT_LEN_HI) begin
					if (idle_count != 32'hFFFF_FFFF) begin
						idle_count++;
					end
					if (idle_count > tick_limit) begin
						push_verdict(VERDICT_TIMEOUT, frame_len);
					end
				end
			end else begin
				idle_count = '0;
				case (phase)
					WAIT_LEN_HI: begin
						crc_acc = crc_update(crc_acc, b);
						frame_len = {b, 8'h00};
						phase = WAIT_LEN_LO;
					end
					WAIT_LEN_LO: begin
						crc_acc = crc_update(crc_acc, b);
						frame_len[7:0] = b;
						if (frame_len < min_len || frame_len > max_len) begin
							push_verdict(VERDICT_BADLEN, frame_len);
						end else begin
							byte_count = '0;
							phase = (frame_len == 0) ? TAKE_CRC : TAKE_BODY;
						end
					end
					TAKE_BODY: begin
						crc_acc = crc_update(crc_acc, b);
						r = '0;
						r.out_kind = KIND_BODY;
						r.body_byte = b;
						r.is_opcode = (byte_count == 0);
						pending.push_back(r);
						byte_count++;
						if (byte_count >= frame_len) begin
							byte_count = '0;
							phase = TAKE_CRC;
						end
					end
					default: begin
						crc_seen = {crc_seen[23:0], b};
						byte_count++;
						if (byte_count >= CrcBytes) begin
							push_verdict(((crc_acc ^ CrcInit) == crc_seen) ?
								VERDICT_OK : VERDICT_BADCRC, frame_len);
						end
					end
				endcase
			end
		endfunction

		function string describe(input out_item_t r);
			return $sformatf("kind %0d byte %02h opcode %0d verdict %0d length %0d",
				r.out_kind, r.body_byte, r.is_opcode, r.verdict, r.frame_length);
		endfunction

		// Compare one accepted result against the oldest expectation
		function void check_result(input out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending: %s", $time, describe(got));
			end else begin
				want = pending.pop_front();
				if (got.out_kind !== want.out_kind || got.body_byte !== want.body_byte ||
						got.is_opcode !== want.is_opcode || got.verdict !== want.verdict ||
						got.frame_length !== want.frame_length) begin
					errors++;
					$display("%0t: mismatch, expected %s, actual %s", $time,
						describe(want), describe(got));
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;

	frame_checker sb;
	int unsigned  cycles = 0;
	int unsigned  items_sent = 0;
	bit           no_gaps = 0;
	bit           hold_req = 0;

	crc32_frame_receiver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(out_data);
		end
	end

	// Stall the output at random throughout; honor a long hold-off when asked
	initial begin : receiver
		int r;
		int n;
		out_stall = 1'b0;
		forever begin
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end else begin
				r = $urandom_range(99, 0);
				if (r < 55) begin
					out_stall = 1'b0;
					n = $urandom_range(24, 1);
				end else if (r < 92) begin
					out_stall = 1'b1;
					n = $urandom_range(3, 1);
				end else begin
					out_stall = 1'b1;
					n = $urandom_range(40, 8);
				end
				repeat (n) @(negedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (no_gaps || r < 65) begin
			return 0;
		end else if (r < 94) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(30, 6);
	endfunction

	// Pick an in-range length, capped at span above the minimum
	function automatic int pick_len(input int span);
		int lo;
		int hi;
		lo = int'(sb.min_len);
		hi = int'(sb.max_len);
		if (hi > lo + span) begin
			hi = lo + span;
		end
		return $urandom_range(hi, lo);
	endfunction

	// Offer one transaction and hold it until accepted
	task automatic send_item(input logic kind, input logic [7:0] data);
		int gap;
		in_item_t it;
		it.cmd = kind;
		it.rx_data = data;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!(kind == CMD_TICK && sb.phase == WAIT_LEN_HI)) begin
			items_sent++;
		end
		sb.note_item(it);
	endtask

	// Send length, random body and CRC, cut after cut bytes; sprinkle ticks
	task automatic drive_frame(input logic [15:0] len, input bit corrupt, input int tick_pct,
			input int cut);
		logic [31:0] c;
		logic [7:0] b;
		int total;
		int i;
		total = int'(len) + 6;
		if (cut < total) begin
			total = cut;
		end
		c = CrcInit;
		for (i = 0; i < total; i++) begin
			if (i < int'(len) + 2) begin
				b = (i == 0) ? len[15:8] : (i == 1) ? len[7:0] : 8'($urandom);
				c = frame_checker::crc_update(c, b);
			end else begin
				if (i == int'(len) + 2) begin
					c = c ^ CrcInit;
					if (corrupt) begin
						c = c ^ (32'h1 << $urandom_range(31, 0));
					end
				end
				b = c[31:24];
				c = {c[23:0], 8'h00};
			end
			send_item(CMD_BYTE, b);
			if (i + 1 < total && $urandom_range(99, 0) < tick_pct) begin
				repeat ($urandom_range(3, 1)) send_item(CMD_TICK, 8'($urandom));
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Drop valid, wait out all expected results and any trailing work
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [15:0] lo_v;
		logic [15:0] hi_v;
		logic [31:0] to_v;
		int tick_pct;
		int start;
		int p;
		int len;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_LENGTH;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset config: good frame, bad crc, idle tick, length below and above range
		drive_frame(16'd1, 0, 0, WHOLE_FRAME);
		drive_frame(16'd1, 1, 0, WHOLE_FRAME);
		send_item(CMD_TICK, 8'hFF);
		drive_frame(16'd0, 0, 0, 2);
		drive_frame(16'd513, 0, 0, 2);
		wait_drained();

		// Widest range, shortest timeout
		write_reg(CFG_MIN_LENGTH, 32'd0);
		write_reg(CFG_MAX_LENGTH, 32'h0000_FFFF);
		write_reg(CFG_TIMEOUT_TICKS, 32'd1);
		drive_frame(16'd0, 0, 0, WHOLE_FRAME);
		drive_frame(16'hFFFF, 0, 0, 3);
		repeat (2) send_item(CMD_TICK, 8'h00);
		send_item(CMD_BYTE, 8'hAB);
		repeat (2) send_item(CMD_TICK, 8'h5A);
		wait_drained();

		// Back-pressure: output held off while a long body streams in
		write_reg(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
		@(negedge clk);
		hold_req = 1;
		no_gaps = 1;
		drive_frame(16'd120, 0, 0, WHOLE_FRAME);
		no_gaps = 0;
		wait_drained();

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(9, 0) == 0) begin
				lo_v = 16'hFFFF;
				hi_v = 16'hFFFF;
			end else begin
				case ($urandom_range(2, 0))
					0: lo_v = 16'd0;
					1: lo_v = 16'd1;
					default: lo_v = 16'($urandom_range(8, 2));
				endcase
				case ($urandom_range(3, 0))
					0: hi_v = 16'hFFFF;
					1: hi_v = lo_v + 16'($urandom_range(3, 0));
					2: hi_v = 16'd512;
					default: hi_v = lo_v + 16'($urandom_range(40, 4));
				endcase
				if (hi_v == 0) begin
					hi_v = 16'd1;
				end
			end
			case ($urandom_range(3, 0))
				0: to_v = 32'd1;
				1: to_v = $urandom_range(6, 2);
				2: to_v = 32'd100;
				default: to_v = 32'hFFFF_FFFF;
			endcase
			write_reg(CFG_MIN_LENGTH, {16'h0, lo_v});
			write_reg(CFG_MAX_LENGTH, {16'h0, hi_v});
			write_reg(CFG_TIMEOUT_TICKS, to_v);
			case ($urandom_range(2, 0))
				0: tick_pct = 0;
				1: tick_pct = 10;
				default: tick_pct = 30;
			endcase
			no_gaps = ($urandom_range(3, 0) == 0);
			start = items_sent;
			while (items_sent - start < 90 && items_sent < RANDOM_ITEMS) begin
				p = $urandom_range(99, 0);
				// Only bad lengths fit when the minimum is huge
				if (sb.min_len > 600) begin
					p = 75;
				end
				if (p < 70) begin
					len = pick_len(($urandom_range(39, 0) == 0) ? 200 : 24);
					drive_frame(16'(len), $urandom_range(4, 0) == 0, tick_pct, WHOLE_FRAME);
				end else if (p < 82) begin
					if (sb.min_len > 0 && (sb.max_len == 16'hFFFF || $urandom_range(1, 0))) begin
						drive_frame(16'($urandom_range(int'(sb.min_len) - 1, 0)), 0, 0, 2);
					end else if (sb.max_len < 16'hFFFF) begin
						drive_frame(16'($urandom_range(16'hFFFF, int'(sb.max_len) + 1)), 0, 0, 2);
					end else begin
						drive_frame(16'(pick_len(24)), 0, tick_pct, WHOLE_FRAME);
					end
				end else if (p < 92) begin
					// Broken frame, then ticks to time it out when the limit is short
					len = pick_len(24);
					drive_frame(16'(len), 0, tick_pct, $urandom_range(len + 5, 1));
					if (sb.tick_limit <= 8) begin
						repeat (sb.tick_limit + 1) send_item(CMD_TICK, 8'($urandom));
					end
				end else begin
					repeat ($urandom_range(6, 1)) begin
						send_item(1'($urandom_range(1, 0)), 8'($urandom));
					end
				end
			end
			no_gaps = 0;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule

### sim.f
+incdir+rtl
rtl/crcfr_pkg.sv
rtl/crcfr_parser.sv
rtl/crc32_frame_receiver.sv
tb/tb.sv
